### rtl/qci_pkg.sv
package qci_pkg;

    localparam int COORD_W = 16;
    localparam int SIZE_W  = 11;
    localparam int FRAC_W  = 4;
    localparam int SCALED_W = SIZE_W + FRAC_W;

    localparam int LEVEL_W = 4;
    localparam int CODE_W  = 16;
    localparam int INDEX_W = 17;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_FIELD_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FIELD_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAX_LEVEL    = 2'd2;

    localparam logic [SIZE_W-1:0]  FIELD_WIDTH_RST  = 11'd384;
    localparam logic [SIZE_W-1:0]  FIELD_HEIGHT_RST = 11'd448;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST    = 4'd4;

    // first index of a level: (4^level - 1) / 3
    function automatic logic [INDEX_W-1:0] tree_base(input logic [LEVEL_W-1:0] level);
        logic [INDEX_W-1:0] base;
        begin
            case (level)
                4'd0:    base = 17'd0;
                4'd1:    base = 17'd1;
                4'd2:    base = 17'd5;
                4'd3:    base = 17'd21;
                4'd4:    base = 17'd85;
                4'd5:    base = 17'd341;
                4'd6:    base = 17'd1365;
                4'd7:    base = 17'd5461;
                4'd8:    base = 17'd21845;
                default: base = 17'd0;
            endcase
            return base;
        end
    endfunction

endpackage

### rtl/qci_div_lane.sv
module qci_div_lane #(
    parameter int STEPS = 8
) (
    input  logic                                clk,
    input  logic signed [qci_pkg::COORD_W-1:0]  coord,
    input  logic [qci_pkg::SIZE_W-1:0]          size_eff,
    output logic [STEPS-1:0]                    quotient
);

    localparam int NSTG = (STEPS + 1) / 2;
    localparam int RW   = qci_pkg::SCALED_W;

    logic [RW-1:0]    divisor;
    logic [RW-1:0]    clamp_hi;
    logic [RW-1:0]    cc_next;
    logic [RW-1:0]    cc_reg;
    logic [RW-1:0]    rem_src [NSTG];
    logic [STEPS-1:0] quo_src [NSTG];
    logic [RW-1:0]    rem_next [NSTG];
    logic [STEPS-1:0] quo_next [NSTG];
    logic [RW-1:0]    rem_reg [NSTG];
    logic [STEPS-1:0] quo_reg [NSTG];

    assign divisor  = {size_eff, {qci_pkg::FRAC_W{1'b0}}};
    assign clamp_hi = {size_eff - 1'b1, {qci_pkg::FRAC_W{1'b0}}};

    // clamp to [0, (size - 1) whole units]
    always_comb
    begin
        if (coord[qci_pkg::COORD_W-1])
        begin
            cc_next = '0;
        end
        else if (coord[RW-1:0] > clamp_hi)
        begin
            cc_next = clamp_hi;
        end
        else
        begin
            cc_next = coord[RW-1:0];
        end
    end

    // restoring division, two quotient bits per stage
    always_comb
    begin
        logic [RW:0]      r2;
        logic [RW-1:0]    r;
        logic [STEPS-1:0] q;
        logic             b;
        rem_src[0] = cc_reg;
        quo_src[0] = '0;
        for (int s = 1; s < NSTG; s++)
        begin
            rem_src[s] = rem_reg[s-1];
            quo_src[s] = quo_reg[s-1];
        end
        for (int s = 0; s < NSTG; s++)
        begin
            r = rem_src[s];
            q = quo_src[s];
            for (int j = 0; j < 2; j++)
            begin
                if (2 * s + j < STEPS)
                begin
                    r2 = {r, 1'b0};
                    b  = (r2 >= {1'b0, divisor});
                    if (b)
                    begin
                        r2 = r2 - {1'b0, divisor};
                    end
                    r = r2[RW-1:0];
                    q[STEPS-1-(2*s+j)] = b;
                end
            end
            rem_next[s] = r;
            quo_next[s] = q;
        end
    end

    always_ff @(posedge clk)
    begin
        cc_reg <= cc_next;
        for (int s = 0; s < NSTG; s++)
        begin
            rem_reg[s] <= rem_next[s];
            quo_reg[s] <= quo_next[s];
        end
    end

    assign quotient = quo_reg[NSTG-1];

endmodule

### rtl/quadtree_cell_index.sv
// Linear quadtree cell index. One bounding box is accepted per clock and busy
// stays low; each box yields one result, marked by a one-cycle done strobe.
// The pipeline is made up of the four clamp-and-divide lanes, which are
// restoring dividers resolving two quotient bits per pipeline stage, followed
// by a Morton interleave stage and a level search / index add stage. Results
// arrive in the order boxes were accepted and cannot be held off by the
// receiver. The user must write configuration registers through the APB port
// only while no box is in flight; the block itself does not enforce this.
module quadtree_cell_index #(
    parameter int MAX_LEVEL_LIMIT = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [qci_pkg::COORD_W-1:0]  box_left,
    input  logic signed [qci_pkg::COORD_W-1:0]  box_top,
    input  logic signed [qci_pkg::COORD_W-1:0]  box_right,
    input  logic signed [qci_pkg::COORD_W-1:0]  box_bottom,
    output logic                                done,
    output logic [qci_pkg::INDEX_W-1:0]         tree_index,
    output logic [qci_pkg::LEVEL_W-1:0]         cell_level,
    output logic [qci_pkg::CODE_W-1:0]          cell_code,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qci_pkg::ADDR_W-1:0]          paddr,
    input  logic [qci_pkg::DATA_W-1:0]          pwdata,
    output logic [qci_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    localparam int P     = MAX_LEVEL_LIMIT;
    localparam int NSTG  = (P + 1) / 2;
    localparam int LVW   = $clog2(P + 1);
    localparam int DEPTH = NSTG + 3;

    logic [qci_pkg::SIZE_W-1:0]  field_width_reg;
    logic [qci_pkg::SIZE_W-1:0]  field_height_reg;
    logic [qci_pkg::LEVEL_W-1:0] max_level_reg;
    logic                        cfg_write;

    logic [qci_pkg::SIZE_W-1:0]  width_eff;
    logic [qci_pkg::SIZE_W-1:0]  height_eff;
    logic [LVW-1:0]              lv;

    logic [P-1:0]   qx1;
    logic [P-1:0]   qy1;
    logic [P-1:0]   qx2;
    logic [P-1:0]   qy2;
    logic [P-1:0]   x1;
    logic [P-1:0]   y1;
    logic [P-1:0]   x2;
    logic [P-1:0]   y2;
    logic [2*P-1:0] m1_next;
    logic [2*P-1:0] m2_next;
    logic [2*P-1:0] m1_reg;
    logic [2*P-1:0] m2_reg;

    logic [2*P-1:0]              diff;
    logic [LVW-1:0]              k;
    logic [LVW-1:0]              level;
    logic [qci_pkg::CODE_W-1:0]  code_next;
    logic [qci_pkg::INDEX_W-1:0] index_next;
    logic [qci_pkg::INDEX_W-1:0] tree_index_reg;
    logic [qci_pkg::LEVEL_W-1:0] cell_level_reg;
    logic [qci_pkg::CODE_W-1:0]  cell_code_reg;

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg  <= qci_pkg::FIELD_WIDTH_RST;
            field_height_reg <= qci_pkg::FIELD_HEIGHT_RST;
            max_level_reg    <= qci_pkg::MAX_LEVEL_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                qci_pkg::REG_FIELD_WIDTH:  field_width_reg  <= pwdata[qci_pkg::SIZE_W-1:0];
                qci_pkg::REG_FIELD_HEIGHT: field_height_reg <= pwdata[qci_pkg::SIZE_W-1:0];
                qci_pkg::REG_MAX_LEVEL:    max_level_reg    <= pwdata[qci_pkg::LEVEL_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            qci_pkg::REG_FIELD_WIDTH:  prdata = qci_pkg::DATA_W'(field_width_reg);
            qci_pkg::REG_FIELD_HEIGHT: prdata = qci_pkg::DATA_W'(field_height_reg);
            qci_pkg::REG_MAX_LEVEL:    prdata = qci_pkg::DATA_W'(max_level_reg);
            default:                   prdata = '0;
        endcase
    end

    assign width_eff  = (field_width_reg == '0) ? qci_pkg::SIZE_W'(1) : field_width_reg;
    assign height_eff = (field_height_reg == '0) ? qci_pkg::SIZE_W'(1) : field_height_reg;
    assign lv         = (32'(max_level_reg) > P) ? LVW'(P) : LVW'(max_level_reg);

    // transaction tracking, the pipeline never stalls
    assign busy = 1'b0;
    assign valid_next = {valid_reg[DEPTH-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // clamp and scale lanes
    qci_div_lane #(.STEPS(P)) u_lane_x1 (
        .clk      (clk),
        .coord    (box_left),
        .size_eff (width_eff),
        .quotient (qx1)
    );

    qci_div_lane #(.STEPS(P)) u_lane_y1 (
        .clk      (clk),
        .coord    (box_top),
        .size_eff (height_eff),
        .quotient (qy1)
    );

    qci_div_lane #(.STEPS(P)) u_lane_x2 (
        .clk      (clk),
        .coord    (box_right),
        .size_eff (width_eff),
        .quotient (qx2)
    );

    qci_div_lane #(.STEPS(P)) u_lane_y2 (
        .clk      (clk),
        .coord    (box_bottom),
        .size_eff (height_eff),
        .quotient (qy2)
    );

    // keep the top lv quotient bits, then interleave
    assign x1 = qx1 >> (LVW'(P) - lv);
    assign y1 = qy1 >> (LVW'(P) - lv);
    assign x2 = qx2 >> (LVW'(P) - lv);
    assign y2 = qy2 >> (LVW'(P) - lv);

    always_comb
    begin
        for (int i = 0; i < P; i++)
        begin
            m1_next[2*i]   = x1[i];
            m1_next[2*i+1] = y1[i];
            m2_next[2*i]   = x2[i];
            m2_next[2*i+1] = y2[i];
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg <= m1_next;
        m2_reg <= m2_next;
    end

    // highest differing group picks the level
    assign diff = m1_reg ^ m2_reg;

    always_comb
    begin
        k = '0;
        for (int i = 0; i < P; i++)
        begin
            if ((LVW'(i) < lv) && (diff[2*i +: 2] != 2'b00))
            begin
                k = LVW'(i + 1);
            end
        end
    end

    assign level      = lv - k;
    assign code_next  = qci_pkg::CODE_W'(m2_reg >> {k, 1'b0});
    assign index_next = qci_pkg::tree_base(qci_pkg::LEVEL_W'(level))
                      + qci_pkg::INDEX_W'(code_next);

    always_ff @(posedge clk)
    begin
        tree_index_reg <= index_next;
        cell_level_reg <= qci_pkg::LEVEL_W'(level);
        cell_code_reg  <= code_next;
    end

    assign done       = valid_reg[DEPTH-1];
    assign tree_index = tree_index_reg;
    assign cell_level = cell_level_reg;
    assign cell_code  = cell_code_reg;

endmodule

### test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVEL_CAP = 8;
    localparam int LATENCY = (LEVEL_CAP + 1) / 2 + 3;
    localparam int PHASES = 8;
    localparam int BOXES_PER_PHASE = 190;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [qci_pkg::INDEX_W-1:0] index;
        logic [qci_pkg::LEVEL_W-1:0] level;
        logic [qci_pkg::CODE_W-1:0]  code;
    } cell_result_t;

    class cell_index_tracker;
        logic [qci_pkg::SIZE_W-1:0]  width_reg;
        logic [qci_pkg::SIZE_W-1:0]  height_reg;
        logic [qci_pkg::LEVEL_W-1:0] level_reg;
        cell_result_t                pending_cells[$];
        int                          errors;

        function new();
            width_reg  = qci_pkg::FIELD_WIDTH_RST;
            height_reg = qci_pkg::FIELD_HEIGHT_RST;
            level_reg  = qci_pkg::MAX_LEVEL_RST;
            errors     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [qci_pkg::DATA_W-1:0] value);
            case (idx)
                qci_pkg::REG_FIELD_WIDTH:  width_reg  = value[qci_pkg::SIZE_W-1:0];
                qci_pkg::REG_FIELD_HEIGHT: height_reg = value[qci_pkg::SIZE_W-1:0];
                qci_pkg::REG_MAX_LEVEL:    level_reg  = value[qci_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            return (width_reg == 0) ? 1 : int'(width_reg);
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : int'(height_reg);
        endfunction

        function int unsigned eff_level();
            return (level_reg > LEVEL_CAP) ? LEVEL_CAP : int'(level_reg);
        endfunction

        function int unsigned to_cell(logic signed [qci_pkg::COORD_W-1:0] c,
                                      int unsigned size, int unsigned lv);
            int hi;
            int v;
            hi = (size - 1) * 16;
            v = int'(c);
            if (v < 0)
                v = 0;
            if (v > hi)
                v = hi;
            return (int'(v) << lv) / (size * 16);
        endfunction

        function logic [31:0] interleave(int unsigned x, int unsigned y);
            logic [31:0] m;
            m = '0;
            for (int i = 0; i < 16; i++)
            begin
                m[2*i]   = x[i];
                m[2*i+1] = y[i];
            end
            return m;
        endfunction

        function cell_result_t predict_cell(logic signed [qci_pkg::COORD_W-1:0] l,
                                            logic signed [qci_pkg::COORD_W-1:0] t,
                                            logic signed [qci_pkg::COORD_W-1:0] r,
                                            logic signed [qci_pkg::COORD_W-1:0] b);
            cell_result_t res;
            int unsigned  w;
            int unsigned  h;
            int unsigned  lv;
            int unsigned  k;
            int unsigned  lvl;
            logic [31:0]  m1;
            logic [31:0]  m2;
            logic [31:0]  diff;
            logic [31:0]  code;
            logic [31:0]  base;
            w  = eff_width();
            h  = eff_height();
            lv = eff_level();
            m1 = interleave(to_cell(l, w, lv), to_cell(t, h, lv));
            m2 = interleave(to_cell(r, w, lv), to_cell(b, h, lv));
            diff = m1 ^ m2;
            k = 0;
            for (int unsigned i = 0; i < lv; i++)
            begin
                if (diff[2*i +: 2] != 2'b00)
                    k = i + 1;
            end
            lvl  = lv - k;
            code = (m2 >> (2 * k)) & 32'hFFFF;
            base = ((32'd1 << (2 * lvl)) - 1) / 3;
            res.index = qci_pkg::INDEX_W'(base + code);
            res.level = lvl[qci_pkg::LEVEL_W-1:0];
            res.code  = code[qci_pkg::CODE_W-1:0];
            return res;
        endfunction

        function void note_box(logic signed [qci_pkg::COORD_W-1:0] l,
                               logic signed [qci_pkg::COORD_W-1:0] t,
                               logic signed [qci_pkg::COORD_W-1:0] r,
                               logic signed [qci_pkg::COORD_W-1:0] b);
            pending_cells = {pending_cells, predict_cell(l, t, r, b)};
        endfunction

        function void check_cell(logic [qci_pkg::INDEX_W-1:0] index,
                                 logic [qci_pkg::LEVEL_W-1:0] level,
                                 logic [qci_pkg::CODE_W-1:0] code);
            cell_result_t exp_cell;
            if (pending_cells.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transaction: index %0d level %0d code %0h",
                             index, level, code);
                return;
            end
            exp_cell = pending_cells[0];
            pending_cells.delete(0);
            if (exp_cell.index !== index || exp_cell.level !== level ||
                exp_cell.code !== code)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp index %0d level %0d code %0h, got %0d %0d %0h",
                             exp_cell.index, exp_cell.level, exp_cell.code,
                             index, level, code);
            end
        endfunction

        function int pending();
            return pending_cells.size();
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic signed [qci_pkg::COORD_W-1:0]  box_left = '0;
    logic signed [qci_pkg::COORD_W-1:0]  box_top = '0;
    logic signed [qci_pkg::COORD_W-1:0]  box_right = '0;
    logic signed [qci_pkg::COORD_W-1:0]  box_bottom = '0;
    logic                                done;
    logic [qci_pkg::INDEX_W-1:0]         tree_index;
    logic [qci_pkg::LEVEL_W-1:0]         cell_level;
    logic [qci_pkg::CODE_W-1:0]          cell_code;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [qci_pkg::ADDR_W-1:0]          paddr = '0;
    logic [qci_pkg::DATA_W-1:0]          pwdata = '0;
    logic [qci_pkg::DATA_W-1:0]          prdata;
    logic                                pready;

    cell_index_tracker tracker = new();
    int burst_left = 0;
    bit no_gaps = 1'b0;

    quadtree_cell_index u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_right  (box_right),
        .box_bottom (box_bottom),
        .done       (done),
        .tree_index (tree_index),
        .cell_level (cell_level),
        .cell_code  (cell_code),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_cell(tree_index, cell_level, cell_code);
    end

    function automatic int draw_gap();
        if (burst_left == 0)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(10, 60);
        end
        burst_left--;
        return no_gaps ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic signed [qci_pkg::COORD_W-1:0] clip16(int v);
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return v[qci_pkg::COORD_W-1:0];
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [qci_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(idx, value);
    endtask

    task automatic send_box(logic signed [qci_pkg::COORD_W-1:0] l,
                            logic signed [qci_pkg::COORD_W-1:0] t,
                            logic signed [qci_pkg::COORD_W-1:0] r,
                            logic signed [qci_pkg::COORD_W-1:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        box_left   <= l;
        box_top    <= t;
        box_right  <= r;
        box_bottom <= b;
        start      <= 1'b1;
        do @(posedge clk); while (busy);
        tracker.note_box(l, t, r, b);
    endtask

    // near edge somewhere around the field, far edge a span of random scale away
    task automatic random_span(int unsigned size, bit flip,
                               output logic signed [qci_pkg::COORD_W-1:0] lo,
                               output logic signed [qci_pkg::COORD_W-1:0] hi);
        int near_c;
        int span;
        near_c = int'($urandom_range(0, size * 16 + 63)) - 32;
        span = $urandom_range(0, (size * 16) >> $urandom_range(0, 12));
        lo = clip16(flip ? near_c + span : near_c);
        hi = clip16(flip ? near_c : near_c + span);
    endtask

    task automatic random_box();
        logic signed [qci_pkg::COORD_W-1:0] l;
        logic signed [qci_pkg::COORD_W-1:0] t;
        logic signed [qci_pkg::COORD_W-1:0] r;
        logic signed [qci_pkg::COORD_W-1:0] b;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            l = qci_pkg::COORD_W'($urandom);
            t = qci_pkg::COORD_W'($urandom);
            r = qci_pkg::COORD_W'($urandom);
            b = qci_pkg::COORD_W'($urandom);
        end
        else
        begin
            random_span(tracker.eff_width(), kind == 1 && $urandom_range(0, 1), l, r);
            random_span(tracker.eff_height(), kind == 1 && $urandom_range(0, 1), t, b);
        end
        send_box(l, t, r, b);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    task automatic apply_phase(int p);
        case (p)
            1:
            begin
                write_reg(qci_pkg::REG_FIELD_WIDTH, 32'd2047);
                write_reg(qci_pkg::REG_FIELD_HEIGHT, 32'd2047);
                write_reg(qci_pkg::REG_MAX_LEVEL, 32'd8);
            end
            2:
            begin
                write_reg(qci_pkg::REG_FIELD_WIDTH, 32'd1);
                write_reg(qci_pkg::REG_FIELD_HEIGHT, 32'd1);
                write_reg(qci_pkg::REG_MAX_LEVEL, 32'd0);
            end
            3:
            begin
                write_reg(qci_pkg::REG_FIELD_WIDTH, 32'd0);
                write_reg(qci_pkg::REG_FIELD_HEIGHT, 32'd0);
                write_reg(qci_pkg::REG_MAX_LEVEL, 32'd15);
            end
            4:
            begin
                write_reg(qci_pkg::REG_FIELD_WIDTH, 32'd640);
                write_reg(qci_pkg::REG_FIELD_HEIGHT, 32'd480);
                write_reg(qci_pkg::REG_MAX_LEVEL, 32'd5);
                write_reg(REG_UNUSED, 32'hFFFF_FFFF);
            end
            5:
            begin
                write_reg(qci_pkg::REG_FIELD_WIDTH, 32'd2047);
                write_reg(qci_pkg::REG_FIELD_HEIGHT, 32'd1);
                write_reg(qci_pkg::REG_MAX_LEVEL, 32'd9);
            end
            6:
            begin
                write_reg(qci_pkg::REG_FIELD_WIDTH, $urandom);
                write_reg(qci_pkg::REG_FIELD_HEIGHT, $urandom);
                write_reg(qci_pkg::REG_MAX_LEVEL, $urandom);
            end
            7:
            begin
                write_reg(qci_pkg::REG_FIELD_WIDTH, $urandom_range(1, 2047));
                write_reg(qci_pkg::REG_FIELD_HEIGHT, $urandom_range(1, 2047));
                write_reg(qci_pkg::REG_MAX_LEVEL, $urandom_range(1, 8));
            end
            default: ;
        endcase
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default field 384 x 448, level 4
        send_box(0, 0, 0, 0);
        send_box(-32768, -32768, -32768, -32768);
        send_box(32767, 32767, 32767, 32767);
        send_box(-32768, -32768, 32767, 32767);
        send_box(6128, 7152, 6128, 7152);
        send_box(6144, 7168, 6144, 7168);
        send_box(-1, -1, 0, 0);
        send_box(100, 100, 110, 110);
        send_box(5000, 5000, 100, 100);
        send_box(0, 0, 383, 447);
        send_box(383, 447, 384, 448);
        send_box(3071, 0, 3072, 0);
        send_box(3072, 3584, 6128, 7152);
        send_box(-32768, 32767, 32767, -32768);
        send_box(16'sh5555, 16'sh2AAA, 16'sh5555, 16'sh2AAA);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            apply_phase(p);
            for (int n = 0; n < BOXES_PER_PHASE; n++)
                random_box();
        end
        drain();

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #1ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
